FILE: hw/rtl/tws_pkg.sv
package tws_pkg;

    localparam int SIZE_DEF       = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int PIVOT_IDX_W    = 4;

    typedef enum logic [4:0] {
        S_LOAD,
        S_POP,
        S_POP_WAIT,
        S_X0,
        S_X1,
        S_X2,
        S_SCAN,
        S_CMP,
        S_RA,
        S_RB,
        S_RC,
        S_FIN,
        S_F1,
        S_F2,
        S_F3,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

endpackage

FILE: hw/rtl/three_way_quicksort.sv
// Channel  Direction  Handshake            Payload
// s_       in         s_tvalid / s_tready  s_tdata: value; s_tlast: last_item
// m_       out        m_tvalid / m_tready  m_tdata: sorted_value; m_tlast: end_of_run;
//                                          m_tuser: overflowed
// cfg_     in         cfg_valid/cfg_ready  cfg_data: first_pivot_index
//
// Loading accepts one request per cycle; a request without tlast returns no result.
// A tlast request with two or more entries starts the sort in the one store memory: each
// range is popped and its pivot fetched, elements are scanned and swapped as needed, and
// the range closes by pushing its sub-ranges. Each result is then read and registered
// onto m_, stalling on m_tready; s_tready stays low until the last result is loaded.
// Reset clears only state, count, stack depth, overflow, first flag, m_tvalid, cfg index.
module three_way_quicksort #(
    parameter int SIZE       = tws_pkg::SIZE_DEF,
    parameter int DATA_WIDTH = tws_pkg::DATA_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]     s_tdata,   // [DATA_WIDTH-1:0] value
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((DATA_WIDTH+7)/8)*8-1:0]     m_tdata,   // [DATA_WIDTH-1:0] sorted_value
    output logic                                m_tlast,
    output logic                                m_tuser,   // [0] overflowed
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tws_pkg::PIVOT_IDX_W-1:0]     cfg_data
);

    localparam int TDW = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int IW  = $clog2(SIZE);
    localparam int CW  = $clog2(SIZE + 1);
    localparam int SW  = 2 * IW;
    localparam int PW  = (CW > tws_pkg::PIVOT_IDX_W) ? CW : tws_pkg::PIVOT_IDX_W;

    tws_pkg::state_t st_reg, st_next;

    logic [CW-1:0]                   count_reg, count_next;
    logic [CW-1:0]                   sp_reg, sp_next;
    logic                            ovf_reg, ovf_next;
    logic                            first_reg, first_next;
    logic                            mv_reg, mv_next;
    logic [tws_pkg::PIVOT_IDX_W-1:0] fpi_reg;

    logic [IW-1:0]         lo_reg, lo_next, hi_reg, hi_next;
    logic [IW-1:0]         i_reg, i_next, m_reg, m_next, j_reg, j_next, k_reg, k_next;
    logic [DATA_WIDTH-1:0] piv_reg, piv_next, b_reg, b_next;
    logic                  lt_reg, lt_next;
    logic [DATA_WIDTH-1:0] mdata_reg, mdata_next;
    logic                  mlast_reg, mlast_next, muser_reg, muser_next;

    logic                  st_wen, st_ren;
    logic [IW-1:0]         st_waddr, st_raddr;
    logic [DATA_WIDTH-1:0] st_wdata, st_rdata;
    logic                  sk_wen, sk_ren;
    logic [IW-1:0]         sk_waddr, sk_raddr;
    logic [SW-1:0]         sk_wdata, sk_rdata;

    logic [IW-1:0] pop_lo, pop_hi, pidx;
    logic [CW-1:0] nm1;
    logic          emit_go, emit_last;

    tws_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (SIZE),
        .AW    (IW)
    ) u_store (
        .clk   (clk),
        .wen   (st_wen),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .ren   (st_ren),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    tws_ram #(
        .WIDTH (SW),
        .DEPTH (SIZE),
        .AW    (IW)
    ) u_stack (
        .clk   (clk),
        .wen   (sk_wen),
        .waddr (sk_waddr),
        .wdata (sk_wdata),
        .ren   (sk_ren),
        .raddr (sk_raddr),
        .rdata (sk_rdata)
    );

    assign cfg_ready = 1'b1;
    assign m_tvalid  = mv_reg;
    assign m_tdata   = TDW'(mdata_reg);
    assign m_tlast   = mlast_reg;
    assign m_tuser   = muser_reg;

    assign pop_lo    = sk_rdata[IW-1:0];
    assign pop_hi    = sk_rdata[SW-1:IW];
    assign nm1       = count_reg - CW'(1);
    assign emit_go   = !mv_reg || m_tready;
    assign emit_last = (CW'(k_reg) + CW'(1)) == count_reg;

    // The first pivot is clamped to the last loaded entry and never below the range.
    always_comb
    begin
        if (first_reg)
        begin
            if (PW'(fpi_reg) > PW'(nm1))
            begin
                pidx = IW'(nm1);
            end
            else
            begin
                pidx = IW'(fpi_reg);
            end
            if (pidx < pop_lo)
            begin
                pidx = pop_lo;
            end
        end
        else
        begin
            pidx = pop_hi;
        end
    end

    always_comb
    begin
        st_next    = st_reg;
        count_next = count_reg;
        sp_next    = sp_reg;
        ovf_next   = ovf_reg;
        first_next = first_reg;
        mv_next    = mv_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        i_next     = i_reg;
        m_next     = m_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        piv_next   = piv_reg;
        b_next     = b_reg;
        lt_next    = lt_reg;
        mdata_next = mdata_reg;
        mlast_next = mlast_reg;
        muser_next = muser_reg;
        s_tready   = 1'b0;
        st_wen     = 1'b0;
        st_waddr   = j_reg;
        st_wdata   = b_reg;
        st_ren     = 1'b0;
        st_raddr   = j_reg;
        sk_wen     = 1'b0;
        sk_waddr   = sp_reg[IW-1:0];
        sk_wdata   = {hi_reg, lo_reg};
        sk_ren     = 1'b0;
        sk_raddr   = sp_reg[IW-1:0];

        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        case (st_reg)
            tws_pkg::S_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (count_reg < CW'(SIZE))
                    begin
                        st_wen     = 1'b1;
                        st_waddr   = count_reg[IW-1:0];
                        st_wdata   = s_tdata[DATA_WIDTH-1:0];
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        k_next = '0;
                        if (count_next < CW'(2))
                        begin
                            st_next = tws_pkg::S_EMIT_RD;
                        end
                        else
                        begin
                            sk_wen     = 1'b1;
                            sk_waddr   = '0;
                            sk_wdata   = {IW'(count_next - CW'(1)), IW'(0)};
                            sp_next    = CW'(1);
                            first_next = 1'b1;
                            st_next    = tws_pkg::S_POP;
                        end
                    end
                end
            end
            tws_pkg::S_POP:
            begin
                if (sp_reg == '0)
                begin
                    k_next  = '0;
                    st_next = tws_pkg::S_EMIT_RD;
                end
                else
                begin
                    sk_ren   = 1'b1;
                    sk_raddr = IW'(sp_reg - CW'(1));
                    sp_next  = sp_reg - CW'(1);
                    st_next  = tws_pkg::S_POP_WAIT;
                end
            end
            tws_pkg::S_POP_WAIT:
            begin
                lo_next = pop_lo;
                hi_next = pop_hi;
                if (pop_hi <= pop_lo || CW'(pop_hi) >= count_reg)
                begin
                    st_next = tws_pkg::S_POP;
                end
                else
                begin
                    first_next = 1'b0;
                    j_next     = pidx;
                    st_ren     = 1'b1;
                    st_raddr   = pidx;
                    st_next    = tws_pkg::S_X0;
                end
            end
            tws_pkg::S_X0:
            begin
                piv_next = st_rdata;
                st_ren   = 1'b1;
                st_raddr = lo_reg;
                st_next  = tws_pkg::S_X1;
            end
            tws_pkg::S_X1:
            begin
                st_wen   = 1'b1;
                st_waddr = j_reg;
                st_wdata = st_rdata;
                st_next  = tws_pkg::S_X2;
            end
            tws_pkg::S_X2:
            begin
                st_wen   = 1'b1;
                st_waddr = lo_reg;
                st_wdata = piv_reg;
                i_next   = lo_reg;
                m_next   = lo_reg;
                j_next   = lo_reg + IW'(1);
                st_next  = tws_pkg::S_SCAN;
            end
            tws_pkg::S_SCAN:
            begin
                st_ren   = 1'b1;
                st_raddr = j_reg;
                st_next  = tws_pkg::S_CMP;
            end
            tws_pkg::S_CMP:
            begin
                b_next = st_rdata;
                if ($signed(st_rdata) <= $signed(piv_reg))
                begin
                    lt_next  = $signed(st_rdata) < $signed(piv_reg);
                    st_ren   = 1'b1;
                    st_raddr = i_reg + IW'(1);
                    i_next   = i_reg + IW'(1);
                    st_next  = tws_pkg::S_RA;
                end
                else if (j_reg == hi_reg)
                begin
                    st_next = tws_pkg::S_FIN;
                end
                else
                begin
                    j_next  = j_reg + IW'(1);
                    st_next = tws_pkg::S_SCAN;
                end
            end
            tws_pkg::S_RA:
            begin
                st_wen   = 1'b1;
                st_waddr = j_reg;
                st_wdata = st_rdata;
                if (lt_reg)
                begin
                    st_ren   = 1'b1;
                    st_raddr = m_reg + IW'(1);
                    m_next   = m_reg + IW'(1);
                end
                st_next = tws_pkg::S_RB;
            end
            tws_pkg::S_RB:
            begin
                st_wen   = 1'b1;
                st_waddr = i_reg;
                if (lt_reg)
                begin
                    st_wdata = st_rdata;
                    st_next  = tws_pkg::S_RC;
                end
                else
                begin
                    st_wdata = b_reg;
                    if (j_reg == hi_reg)
                    begin
                        st_next = tws_pkg::S_FIN;
                    end
                    else
                    begin
                        j_next  = j_reg + IW'(1);
                        st_next = tws_pkg::S_SCAN;
                    end
                end
            end
            tws_pkg::S_RC:
            begin
                st_wen   = 1'b1;
                st_waddr = m_reg;
                st_wdata = b_reg;
                if (j_reg == hi_reg)
                begin
                    st_next = tws_pkg::S_FIN;
                end
                else
                begin
                    j_next  = j_reg + IW'(1);
                    st_next = tws_pkg::S_SCAN;
                end
            end
            tws_pkg::S_FIN:
            begin
                st_ren   = 1'b1;
                st_raddr = m_reg;
                st_next  = tws_pkg::S_F1;
            end
            tws_pkg::S_F1:
            begin
                st_wen   = 1'b1;
                st_waddr = lo_reg;
                st_wdata = st_rdata;
                st_next  = tws_pkg::S_F2;
            end
            tws_pkg::S_F2:
            begin
                st_wen   = 1'b1;
                st_waddr = m_reg;
                st_wdata = piv_reg;
                // The greater region goes below the less region so that the less one pops first.
                if (i_reg < hi_reg && sp_reg < CW'(SIZE))
                begin
                    sk_wen   = 1'b1;
                    sk_wdata = {hi_reg, i_reg + IW'(1)};
                    sp_next  = sp_reg + CW'(1);
                end
                st_next = tws_pkg::S_F3;
            end
            tws_pkg::S_F3:
            begin
                if (m_reg > lo_reg && sp_reg < CW'(SIZE))
                begin
                    sk_wen   = 1'b1;
                    sk_wdata = {m_reg - IW'(1), lo_reg};
                    sp_next  = sp_reg + CW'(1);
                end
                st_next = tws_pkg::S_POP;
            end
            tws_pkg::S_EMIT_RD:
            begin
                st_ren   = 1'b1;
                st_raddr = k_reg;
                st_next  = tws_pkg::S_EMIT_LD;
            end
            tws_pkg::S_EMIT_LD:
            begin
                if (emit_go)
                begin
                    mv_next    = 1'b1;
                    mdata_next = st_rdata;
                    mlast_next = emit_last;
                    muser_next = ovf_reg;
                    if (emit_last)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        sp_next    = '0;
                        st_next    = tws_pkg::S_LOAD;
                    end
                    else
                    begin
                        k_next  = k_reg + IW'(1);
                        st_next = tws_pkg::S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                st_next = tws_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= tws_pkg::S_LOAD;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sp_reg    <= '0;
            ovf_reg   <= 1'b0;
            first_reg <= 1'b0;
            mv_reg    <= 1'b0;
            fpi_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            sp_reg    <= sp_next;
            ovf_reg   <= ovf_next;
            first_reg <= first_next;
            mv_reg    <= mv_next;
            if (cfg_valid)
            begin
                fpi_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        i_reg     <= i_next;
        m_reg     <= m_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        piv_reg   <= piv_next;
        b_reg     <= b_next;
        lt_reg    <= lt_next;
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
        muser_reg <= muser_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SIZE))
        else $error("Loaded count exceeds the store depth.");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= CW'(SIZE))
        else $error("Range stack depth exceeds its capacity.");

    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == tws_pkg::S_SCAN |->
            (m_reg <= i_reg && i_reg < j_reg && j_reg <= hi_reg && lo_reg <= m_reg))
        else $error("Partition indices are out of order.");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == tws_pkg::S_EMIT_LD && emit_go && emit_last) |=>
            (st_reg == tws_pkg::S_LOAD && count_reg == '0 && !ovf_reg && m_tlast))
        else $error("Run did not close after its final result.");
`endif

endmodule

FILE: hw/rtl/tws_ram.sv
module tws_ram #(
    parameter int WIDTH = tws_pkg::DATA_WIDTH_DEF,
    parameter int DEPTH = tws_pkg::SIZE_DEF,
    parameter int AW    = $clog2(tws_pkg::SIZE_DEF)
) (
    input  logic             clk,
    input  logic             wen,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             ren,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds between reads; a read beside a write returns the old entry.
    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
